// ----- src/dgae_pkg.sv -----
// ----------------------------------------------------------------------------
// dgae_pkg
// Shared types and constants of the dual gain adc to energy converter.
// ----------------------------------------------------------------------------
`default_nettype none

package dgae_pkg;

  localparam int LAYERS_DEF   = 32;
  localparam int CHIPS_DEF    = 8;
  localparam int CHANNELS_DEF = 32;

  localparam int STORE_DEPTH = 8192;
  localparam int ADDR_W      = 13;
  localparam int LIN_W       = 23;

  // decimal cell id decode
  localparam logic [22:0] LAYER_DIV   = 23'd100000;
  localparam logic [15:0] LAYER_RECIP = 16'd42949;
  localparam logic [16:0] CHIP_DIV    = 17'd10000;
  localparam logic [10:0] CHIP_RECIP  = 11'd1677;

  localparam logic [15:0] PEAK_MIN = 16'd1600;
  localparam logic [23:0] OUT_MAX  = 24'hFFFFFF;

  // divider geometry
  localparam int DIV_W     = 32;
  localparam int DEN_W     = 16;
  localparam int QUO_W     = 24;
  localparam int DIV_STEPS = QUO_W;

  localparam logic [1:0] CFG_SWITCH_POINT  = 2'd0;
  localparam logic [1:0] CFG_MIP_ENERGY    = 2'd1;
  localparam logic [1:0] CFG_REFERENCE_MIP = 2'd2;

  typedef struct packed {
    logic [15:0] ped_high;
    logic [15:0] ped_low;
    logic [15:0] mip_peak;
    logic [15:0] hl_gain;
    logic [11:0] plateau;
  } cal_t;

  typedef struct packed {
    logic        cmd;
    logic [21:0] cell_id;
    logic        tag_ok;
    logic [31:0] hit_number;
    logic [11:0] adc_high;
    logic [11:0] adc_low;
    cal_t        cal;
  } item_t;

  typedef struct packed {
    logic [21:0] cell_id;
    logic [31:0] hit_number;
    logic        low;
  } side_t;

endpackage

`default_nettype wire

// ----- src/dgae_div.sv -----
// ----------------------------------------------------------------------------
// dgae_div
// Pipelined restoring divider, one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
`default_nettype none

module dgae_div (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [dgae_pkg::DIV_W-1:0]   dividend,
  input  wire logic [dgae_pkg::DEN_W-1:0]   divisor,
  output logic      [dgae_pkg::QUO_W-1:0]   quotient
);

  localparam int NS = dgae_pkg::DIV_STEPS;
  localparam int QW = dgae_pkg::QUO_W;
  localparam int DW = dgae_pkg::DEN_W;
  localparam int HW = dgae_pkg::DIV_W - dgae_pkg::QUO_W;

  logic [DW-1:0] rem  [NS];
  logic [QW-1:0] lo   [NS];
  logic [QW-1:0] quo  [NS];
  logic [DW-1:0] den  [NS];
  logic          sat  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [DW-1:0] src_rem;
    logic [QW-1:0] src_lo;
    logic [QW-1:0] src_quo;
    logic [DW-1:0] src_den;
    logic          src_sat;
    logic [DW:0]   trial;
    logic          take;

    if (k == 0) begin : g_first
      assign src_rem = DW'(dividend[dgae_pkg::DIV_W-1:QW]);
      assign src_lo  = dividend[QW-1:0];
      assign src_quo = '0;
      assign src_den = divisor;
      assign src_sat = (DW'(dividend[dgae_pkg::DIV_W-1:QW]) >= divisor);
    end else begin : g_next
      assign src_rem = rem[k-1];
      assign src_lo  = lo[k-1];
      assign src_quo = quo[k-1];
      assign src_den = den[k-1];
      assign src_sat = sat[k-1];
    end

    assign trial = {src_rem, src_lo[QW-1]};
    assign take  = (trial >= {1'b0, src_den});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= take ? DW'(trial - {1'b0, src_den}) : trial[DW-1:0];
        lo[k]  <= {src_lo[QW-2:0], 1'b0};
        quo[k] <= {src_quo[QW-2:0], take};
        den[k] <= src_den;
        sat[k] <= src_sat;
      end
    end
  end

  // headroom check covers the bits above the quotient width
  logic unused_hw;
  assign unused_hw = (HW > 0);

  assign quotient = (sat[NS-1] && unused_hw) ? dgae_pkg::OUT_MAX : quo[NS-1];

endmodule

`default_nettype wire

// ----- src/dual_gain_adc_to_energy.sv -----
// ----------------------------------------------------------------------------
// dual_gain_adc_to_energy
// Calibrates calorimeter hits from dual gain adc counts to mip count and energy.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle, hit or calibration write alike, and
// passes a hit through ten stages that decode the decimal cell id, access
// the calibration table and form the numerators, then two 24-stage dividers
// (one quotient bit per stage) that divide in parallel by the mip peak, or
// by the reference mip if the peak is 1600 or less, and an output register
// that holds the result. After reset a clearing pass zeroes the 8192-entry
// table, one entry per cycle; meanwhile in_stall is high while configuration
// writes are taken as usual. Output back pressure stalls the whole pipeline.
`default_nettype none

module dual_gain_adc_to_energy #(
  parameter int LAYERS   = dgae_pkg::LAYERS_DEF,
  parameter int CHIPS    = dgae_pkg::CHIPS_DEF,
  parameter int CHANNELS = dgae_pkg::CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        cmd,
  input  wire logic [21:0] cell_id,
  input  wire logic [7:0]  hit_tag,
  input  wire logic [31:0] hit_number,
  input  wire logic [11:0] adc_high,
  input  wire logic [11:0] adc_low,
  input  wire logic [15:0] ped_high,
  input  wire logic [15:0] ped_low,
  input  wire logic [15:0] mip_peak,
  input  wire logic [15:0] hl_gain,
  input  wire logic [11:0] plateau,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [21:0]      out_cell_id,
  output logic [31:0]      out_hit_number,
  output logic [23:0]      mip_count,
  output logic [23:0]      energy,
  output logic             used_low_gain,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int AW = dgae_pkg::ADDR_W;
  localparam int LW = dgae_pkg::LIN_W;
  localparam int NS = dgae_pkg::DIV_STEPS;

  localparam logic [5:0]  LAYER_LIM = 6'(LAYERS);
  localparam logic [3:0]  CHIP_LIM  = 4'(CHIPS);
  localparam logic [13:0] CHAN_LIM  = 14'(CHANNELS);

  // configuration registers
  logic [11:0] switch_point;
  logic [15:0] mip_energy;
  logic [15:0] reference_mip;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      switch_point  <= '0;
      mip_energy    <= '0;
      reference_mip <= 16'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        dgae_pkg::CFG_SWITCH_POINT:  switch_point  <= cfg_data[11:0];
        dgae_pkg::CFG_MIP_ENERGY:    mip_energy    <= cfg_data;
        dgae_pkg::CFG_REFERENCE_MIP: reference_mip <= cfg_data;
        default: ;
      endcase
    end
  end

  // table clearing pass
  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(dgae_pkg::STORE_DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  logic en;
  logic accept;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en || clr_busy;
  assign accept   = in_valid && !in_stall;

  // stage 1: capture, layer reciprocal product
  dgae_pkg::item_t in_item;
  dgae_pkg::item_t s1_item;
  logic            s1_valid;
  logic [37:0]     s1_prod;

  always_comb begin
    in_item.cmd            = cmd;
    in_item.cell_id        = cell_id;
    in_item.tag_ok         = (hit_tag != 8'd0);
    in_item.hit_number     = hit_number;
    in_item.adc_high       = adc_high;
    in_item.adc_low        = adc_low;
    in_item.cal.ped_high   = ped_high;
    in_item.cal.ped_low    = ped_low;
    in_item.cal.mip_peak   = mip_peak;
    in_item.cal.hl_gain    = hl_gain;
    in_item.cal.plateau    = plateau;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item <= in_item;
      s1_prod <= 38'(cell_id) * 38'(dgae_pkg::LAYER_RECIP);
    end
  end

  // stage 2: layer and remainder
  dgae_pkg::item_t s2_item;
  logic            s2_valid;
  logic [5:0]      s2_layer;
  logic [16:0]     s2_rem;
  logic [5:0]      lay_est;
  logic [22:0]     lay_rem;

  assign lay_est = s1_prod[37:32];
  assign lay_rem = 23'(s1_item.cell_id) - 23'(23'(lay_est) * dgae_pkg::LAYER_DIV);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_item <= s1_item;
      if (lay_rem >= dgae_pkg::LAYER_DIV) begin
        s2_layer <= lay_est + 6'd1;
        s2_rem   <= 17'(lay_rem - dgae_pkg::LAYER_DIV);
      end else begin
        s2_layer <= lay_est;
        s2_rem   <= lay_rem[16:0];
      end
    end
  end

  // stage 3: chip reciprocal product
  dgae_pkg::item_t s3_item;
  logic            s3_valid;
  logic [5:0]      s3_layer;
  logic [16:0]     s3_rem;
  logic [27:0]     s3_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_item  <= s2_item;
      s3_layer <= s2_layer;
      s3_rem   <= s2_rem;
      s3_prod  <= 28'(s2_rem) * 28'(dgae_pkg::CHIP_RECIP);
    end
  end

  // stage 4: chip and channel
  dgae_pkg::item_t s4_item;
  logic            s4_valid;
  logic [5:0]      s4_layer;
  logic [3:0]      s4_chip;
  logic [13:0]     s4_chan;
  logic [3:0]      chip_est;
  logic [16:0]     chip_rem;

  assign chip_est = s3_prod[27:24];
  assign chip_rem = s3_rem - 17'(17'(chip_est) * dgae_pkg::CHIP_DIV);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_item  <= s3_item;
      s4_layer <= s3_layer;
      if (chip_rem >= dgae_pkg::CHIP_DIV) begin
        s4_chip <= chip_est + 4'd1;
        s4_chan <= 14'(chip_rem - dgae_pkg::CHIP_DIV);
      end else begin
        s4_chip <= chip_est;
        s4_chan <= chip_rem[13:0];
      end
    end
  end

  // stage 5: range check, layer and chip row
  dgae_pkg::item_t s5_item;
  logic            s5_valid;
  logic            s5_ok;
  logic [8:0]      s5_row;
  logic [13:0]     s5_chan;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_item <= s4_item;
      s5_chan <= s4_chan;
      s5_row  <= 9'(9'(s4_layer) * 9'(CHIP_LIM)) + 9'(s4_chip);
      s5_ok   <= (s4_layer < LAYER_LIM) && (s4_chip < CHIP_LIM) && (s4_chan < CHAN_LIM);
    end
  end

  // stage 6: linear table index
  dgae_pkg::item_t s6_item;
  logic            s6_valid;
  logic            s6_ok;
  logic [AW-1:0]   s6_addr;
  logic [LW-1:0]   lin;

  assign lin = LW'(LW'(s5_row) * LW'(CHAN_LIM)) + LW'(s5_chan);

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (en) begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_item <= s5_item;
      s6_ok   <= s5_ok && (lin[LW-1:AW] == '0);
      s6_addr <= lin[AW-1:0];
    end
  end

  // calibration table
  dgae_pkg::cal_t cal_mem [dgae_pkg::STORE_DEPTH];
  dgae_pkg::cal_t rd;
  logic           wr_en;

  assign wr_en = en && s6_valid && s6_item.cmd && s6_ok;

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      cal_mem[clr_addr] <= '0;
    end else if (wr_en) begin
      cal_mem[s6_addr] <= s6_item.cal;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd <= cal_mem[s6_addr];
    end
  end

  // stage 7: table data available
  logic        s7_valid;
  logic [21:0] s7_cell;
  logic [31:0] s7_hitno;
  logic [11:0] s7_adc_high;
  logic [11:0] s7_adc_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else if (en) begin
      s7_valid <= s6_valid && !s6_item.cmd && s6_item.tag_ok && s6_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_cell     <= s6_item.cell_id;
      s7_hitno    <= s6_item.hit_number;
      s7_adc_high <= s6_item.adc_high;
      s7_adc_low  <= s6_item.adc_low;
    end
  end

  logic [15:0]        peak_sel;
  logic [15:0]        peak;
  logic signed [17:0] dh;
  logic signed [17:0] dl;
  logic signed [17:0] thr;

  assign peak_sel = (rd.mip_peak > dgae_pkg::PEAK_MIN) ? rd.mip_peak : reference_mip;
  assign peak     = (peak_sel == 16'd0) ? 16'd1 : peak_sel;
  assign dh  = signed'({2'b00, s7_adc_high, 4'h0}) - signed'({2'b00, rd.ped_high});
  assign dl  = signed'({2'b00, s7_adc_low, 4'h0}) - signed'({2'b00, rd.ped_low});
  assign thr = signed'({2'b00, rd.plateau, 4'h0}) - signed'({2'b00, switch_point, 4'h0});

  // stage 8: pedestal subtracted values and gain choice
  logic               s8_valid;
  dgae_pkg::side_t    s8_side;
  logic signed [17:0] s8_dh;
  logic signed [17:0] s8_dl;
  logic [15:0]        s8_gain;
  logic [15:0]        s8_peak;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
    end else if (en) begin
      s8_valid <= s7_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_side.cell_id    <= s7_cell;
      s8_side.hit_number <= s7_hitno;
      s8_side.low        <= !(dh < thr);
      s8_dh              <= dh;
      s8_dl              <= dl;
      s8_gain            <= rd.hl_gain;
      s8_peak            <= peak;
    end
  end

  // stage 9: numerator
  logic            s9_valid;
  dgae_pkg::side_t s9_side;
  logic [31:0]     s9_num;
  logic [15:0]     s9_peak;
  logic [31:0]     num_high;
  logic [31:0]     num_low;

  assign num_high = (s8_dh > 18'sd0) ? 32'({s8_dh[15:0], 8'h00}) : 32'd0;
  assign num_low  = (s8_dl > 18'sd0) ? 32'(33'(s8_dl[16:0]) * 33'(s8_gain)) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_valid <= 1'b0;
    end else if (en) begin
      s9_valid <= s8_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_side <= s8_side;
      s9_num  <= s8_side.low ? num_low : num_high;
      s9_peak <= s8_peak;
    end
  end

  // stage 10: energy numerator
  logic            s10_valid;
  dgae_pkg::side_t s10_side;
  logic [31:0]     s10_num;
  logic [47:0]     s10_x;
  logic [15:0]     s10_peak;

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_valid <= 1'b0;
    end else if (en) begin
      s10_valid <= s9_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_side <= s9_side;
      s10_num  <= s9_num;
      s10_x    <= 48'(s9_num) * 48'(mip_energy);
      s10_peak <= s9_peak;
    end
  end

  // dividers
  logic [23:0] q_mip;
  logic [23:0] q_energy;

  dgae_div u_div_mip (
    .clk      (clk),
    .en       (en),
    .dividend (s10_num),
    .divisor  (s10_peak),
    .quotient (q_mip)
  );

  dgae_div u_div_energy (
    .clk      (clk),
    .en       (en),
    .dividend (s10_x[47:16]),
    .divisor  (s10_peak),
    .quotient (q_energy)
  );

  logic            dv_valid [NS];
  dgae_pkg::side_t dv_side  [NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) begin
        dv_valid[i] <= 1'b0;
      end
    end else if (en) begin
      dv_valid[0] <= s10_valid;
      for (int i = 1; i < NS; i++) begin
        dv_valid[i] <= dv_valid[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side[0] <= s10_side;
      for (int i = 1; i < NS; i++) begin
        dv_side[i] <= dv_side[i-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_cell_id    <= dv_side[NS-1].cell_id;
      out_hit_number <= dv_side[NS-1].hit_number;
      used_low_gain  <= dv_side[NS-1].low;
      mip_count      <= q_mip;
      energy         <= q_energy;
    end
  end

  // assertions
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> in_stall)
    else $error("request accepted during table clearing");

  a_clear_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !s1_valid && !wr_en)
    else $error("pipeline active during table clearing");

  a_energy_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> energy <= mip_count)
    else $error("energy exceeds mip count");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(dv_valid[NS-1]) && $stable(s10_valid))
    else $error("pipeline moved under output stall");

endmodule

`default_nettype wire
